/* rtl/fcp_pkg.sv */
// ----------------------------------------------------------------------------
// fcp_pkg
// Request and status codes and the per-cell control bundle shared by the
// queue with cancel and promote.
// ----------------------------------------------------------------------------
package fcp_pkg;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SERVE   = 2'd1,
        REQ_PROMOTE = 2'd2,
        REQ_REMOVE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FIRST    = 3'd4,
        ST_CANCEL   = 3'd5
    } t_status;

    typedef struct packed {
        logic enq;  // tail cell loads the new identifier
        logic fwd;  // cells at or after the hit take the right neighbor
        logic bwd;  // cells up to the hit take the left neighbor
    } t_cell_ctl;

endpackage

/* rtl/fcp_cell.sv */
// ----------------------------------------------------------------------------
// fcp_cell
// One queue slot: holds an identifier, compares it with the target and
// passes the hit flag toward the tail; shifts from either neighbor.
// ----------------------------------------------------------------------------
module fcp_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                  i_clk,
    input  fcp_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic                  i_is_tail,
    input  logic [ID_BITS-1:0]    i_new_id,
    input  logic [ID_BITS-1:0]    i_target_id,
    input  logic [ID_BITS-1:0]    i_left_id,
    input  logic [ID_BITS-1:0]    i_right_id,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_match,
    output logic [ID_BITS-1:0]    o_id
);
    import fcp_pkg::*;

    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] n_id;

    assign o_match = i_occupied && (r_id == i_target_id);
    assign o_seen  = i_seen || o_match;
    assign o_id    = r_id;

    always_comb begin
        n_id = r_id;
        if (i_ctl.enq && i_is_tail) begin
            n_id = i_new_id;
        end else if (i_ctl.fwd && o_seen) begin
            n_id = i_right_id;
        end else if (i_ctl.bwd && !i_seen) begin
            n_id = i_left_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

/* rtl/fifo_with_cancel_and_promote_top.sv */
// ----------------------------------------------------------------------------
// fifo_with_cancel_and_promote_top
// Ordered queue of identifiers with enqueue, serve, promote and remove.
// ----------------------------------------------------------------------------
// Each accepted request is answered by exactly one result, registered in the
// cycle after the transfer. The queue is a row of QUEUE_DEPTH cells, head at
// cell 0; every cell compares its identifier with the target at once and the
// whole row shifts in the same cycle, so a new request can be taken every
// cycle as long as the previous result is taken (a pending result blocks the
// next transfer only when the output side stalls). The compare-and-hit chain
// through the cells sets the cycle time. Identifiers come from a counter that
// starts at 1 and is never reused; once it is exhausted enqueue answers full.
// ----------------------------------------------------------------------------
module fifo_with_cancel_and_promote_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_req_type,
    input  logic [ID_BITS-1:0]                   i_target_id,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_status,
    output logic [ID_BITS-1:0]                   o_result_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_occupancy
);
    import fcp_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                r_out_valid;
    t_status             r_status;
    logic [ID_BITS-1:0]  r_result_id;
    logic [CW-1:0]       r_occupancy;
    logic [CW-1:0]       r_count;
    logic [ID_BITS-1:0]  r_last_id;

    t_status             n_status;
    logic [ID_BITS-1:0]  n_result_id;
    logic [CW-1:0]       n_count;
    logic [ID_BITS-1:0]  n_last_id;
    t_cell_ctl           w_ctl;
    logic                w_seen_head;

    logic                w_accept;
    logic [ID_BITS-1:0]  w_new_id;
    logic [ID_BITS-1:0]  w_id    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] w_seen;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic                w_found;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_new_id    = r_last_id + ID_BITS'(1);
    assign w_found     = |w_match;
    assign w_seen[0]   = w_seen_head;

    // cell row
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        fcp_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_is_tail   (CW'(g) == r_count),
            .i_new_id    (w_new_id),
            .i_target_id (i_target_id),
            .i_left_id   ((g == 0) ? i_target_id : w_id[(g == 0) ? 0 : g - 1]),
            .i_right_id  (w_id[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .i_seen      (w_seen[g]),
            .o_seen      (w_seen[g+1]),
            .o_match     (w_match[g]),
            .o_id        (w_id[g])
        );
    end

    // request decode
    always_comb begin
        n_status    = ST_OK;
        n_result_id = '0;
        n_count     = r_count;
        n_last_id   = r_last_id;
        w_ctl       = '0;
        w_seen_head = 1'b0;
        if (t_req'(i_req_type) == REQ_ENQUEUE) begin
            if ((r_count == CW'(QUEUE_DEPTH)) || (&r_last_id)) begin
                n_status = ST_FULL;
            end else begin
                n_result_id = w_new_id;
                n_last_id   = w_new_id;
                n_count     = r_count + CW'(1);
                w_ctl.enq   = w_accept;
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (t_req'(i_req_type) == REQ_SERVE) begin
            n_result_id = w_id[0];
            n_count     = r_count - CW'(1);
            w_seen_head = 1'b1;
            w_ctl.fwd   = w_accept;
        end else if (i_target_id == '0) begin
            n_status = ST_CANCEL;
        end else if (!w_found) begin
            n_status = ST_NOTFOUND;
        end else if (t_req'(i_req_type) == REQ_REMOVE) begin
            n_result_id = i_target_id;
            n_count     = r_count - CW'(1);
            w_ctl.fwd   = w_accept;
        end else if (w_match[0]) begin
            n_status = ST_FIRST;
        end else begin
            n_result_id = i_target_id;
            w_ctl.bwd   = w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_last_id   <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_last_id   <= n_last_id;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_result_id <= n_result_id;
            r_occupancy <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_result_id = r_result_id;
    assign o_occupancy = r_occupancy;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

    a_zero_id_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_result_id == '0))
        else $error("nonzero id with error status");

    a_result_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_valid && (r_occupancy == r_count)))
        else $error("missing result after transfer");

    a_id_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.enq) |=> (r_last_id == $past(r_last_id) + ID_BITS'(1)))
        else $error("identifier counter skipped");

endmodule

/* test/tb_fifo_with_cancel_and_promote_top.sv */
// ----------------------------------------------------------------------------
// tb_fifo_with_cancel_and_promote_top
// Self-checking bench for the identifier queue with cancel and promote.
// ----------------------------------------------------------------------------
// A behavioral copy of the queue predicts the response to every request at
// the moment its transfer happens; responses are checked in order, field by
// field. Stimulus starts with a short directed run through the corner cases
// (empty, cancel, full, not found, already first), then biased random
// traffic that alternates between filling and draining, and closes with
// three enqueues and a short mixed run of serve, promote and remove requests.
// Both sides idle at random; the output side also holds off once for a long
// stretch so that the input side backs up.
// ----------------------------------------------------------------------------
module tb_fifo_with_cancel_and_promote_top;
    import fcp_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 1250;
    localparam int IDLE_PCT    = 17;
    localparam int CALM_FIRST  = 400;
    localparam int CALM_LAST   = 650;
    localparam int HOLD_AT     = 900;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        t_req        req;
        logic [15:0] target;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] id;
        logic [4:0]  occupancy;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_target_id;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [15:0] o_result_id;
    logic [4:0]  o_occupancy;

    fifo_with_cancel_and_promote_top #(
        .QUEUE_DEPTH(DEPTH),
        .ID_BITS    (16)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_target_id(i_target_id),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status   (o_status),
        .o_result_id(o_result_id),
        .o_occupancy(o_occupancy)
    );

    t_request    request_backlog[$];
    t_response   expected_responses[$];
    logic [15:0] queued_ids[$];
    logic [15:0] last_issued;
    int          xfer_count;
    int          mismatches;
    logic        in_taken;
    int          hold_left;
    logic        hold_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue behavior: one response per request, state updated in place
    function automatic t_response compute_response(t_req req, logic [15:0] tgt);
        t_response   rsp;
        int          pos;
        logic [15:0] hit;
        rsp.status = ST_OK;
        rsp.id     = '0;
        pos        = -1;
        if (req == REQ_ENQUEUE) begin
            if (queued_ids.size() >= DEPTH || last_issued == 16'hFFFF) begin
                rsp.status = ST_FULL;
            end else begin
                last_issued = last_issued + 16'd1;
                queued_ids.push_back(last_issued);
                rsp.id = last_issued;
            end
        end else if (queued_ids.size() == 0) begin
            rsp.status = ST_EMPTY;
        end else if (req == REQ_SERVE) begin
            rsp.id = queued_ids.pop_front();
        end else if (tgt == '0) begin
            rsp.status = ST_CANCEL;
        end else begin
            for (int i = queued_ids.size() - 1; i >= 0; i--) begin
                if (queued_ids[i] == tgt) pos = i;
            end
            if (pos < 0) begin
                rsp.status = ST_NOTFOUND;
            end else if (req == REQ_REMOVE) begin
                rsp.id = queued_ids[pos];
                queued_ids.delete(pos);
            end else if (pos == 0) begin
                rsp.status = ST_FIRST;
            end else begin
                hit = queued_ids[pos];
                queued_ids.delete(pos);
                queued_ids.push_front(hit);
                rsp.id = hit;
            end
        end
        rsp.occupancy = 5'(queued_ids.size());
        return rsp;
    endfunction

    // mostly live identifiers, some cancels, some misses
    function automatic logic [15:0] pick_target();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70 && queued_ids.size() > 0)
            return queued_ids[$urandom_range(queued_ids.size() - 1)];
        if (roll < 80) return '0;
        if (roll < 90) return 16'($urandom);
        return last_issued + 16'($urandom_range(1, 3));
    endfunction

    task automatic send(t_req req, logic [15:0] tgt);
        t_request item;
        while (request_backlog.size() > 2) @(posedge i_clk);
        item.req    = req;
        item.target = tgt;
        request_backlog.push_back(item);
    endtask

    // input side driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            in_taken <= 1'b0;
            if (request_backlog.size() > 0 &&
                ((xfer_count >= CALM_FIRST && xfer_count < CALM_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid  <= 1'b1;
                i_req_type  <= request_backlog[0].req;
                i_target_id <= request_backlog[0].target;
                void'(request_backlog.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side ready, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && xfer_count >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (xfer_count >= CALM_FIRST && xfer_count < CALM_LAST) ||
                           ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_responses.size() == 0) begin
                    if (mismatches < MAX_SHOWN)
                        $display("unexpected response: status %0d id %0d occupancy %0d",
                                 o_status, o_result_id, o_occupancy);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_responses.pop_front();
                    if (o_status !== want.status || o_result_id !== want.id ||
                        o_occupancy !== want.occupancy) begin
                        if (mismatches < MAX_SHOWN)
                            $display({"mismatch: expected status %0d id %0d occupancy %0d,",
                                      " got status %0d id %0d occupancy %0d"},
                                     want.status, want.id, want.occupancy,
                                     o_status, o_result_id, o_occupancy);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_responses.push_back(
                    compute_response(t_req'(i_req_type), i_target_id));
                xfer_count <= xfer_count + 1;
                in_taken   <= 1'b1;
            end
        end
    end

    initial begin
        #20000000;
        $display("fifo_with_cancel_and_promote_top regression: fail");
        $finish;
    end

    initial begin
        int          enq_pct;
        int          roll;
        logic [15:0] tgt;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = REQ_ENQUEUE;
        i_target_id = '0;
        i_out_ready = 1'b0;
        in_taken    = 1'b0;
        hold_left   = 0;
        hold_done   = 1'b0;
        xfer_count  = 0;
        mismatches  = 0;
        last_issued = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty queue, fill to full, then each special case
        send(REQ_SERVE, 16'd0);
        send(REQ_PROMOTE, 16'd0);
        send(REQ_REMOVE, 16'd5);
        repeat (DEPTH + 1) send(REQ_ENQUEUE, 16'hFFFF);
        send(REQ_PROMOTE, 16'd1);
        send(REQ_PROMOTE, 16'd16);
        send(REQ_PROMOTE, 16'd0);
        send(REQ_REMOVE, 16'd0);
        send(REQ_REMOVE, 16'hFFFF);
        send(REQ_PROMOTE, 16'hAAAA);
        send(REQ_REMOVE, 16'd8);
        send(REQ_SERVE, 16'h5555);

        // random traffic, alternating fill-heavy and drain-heavy runs
        for (int n = 0; n < RAND_ITEMS; n++) begin
            enq_pct = ((n / 100) % 2 == 0) ? 55 : 20;
            roll    = $urandom_range(99);
            tgt     = pick_target();
            if (roll < enq_pct)
                send(REQ_ENQUEUE, tgt);
            else if (roll < enq_pct + (100 - enq_pct) / 3)
                send(REQ_SERVE, tgt);
            else if (roll < enq_pct + 2 * (100 - enq_pct) / 3)
                send(REQ_PROMOTE, tgt);
            else
                send(REQ_REMOVE, tgt);
        end

        repeat (3) send(REQ_ENQUEUE, 16'($urandom));
        for (int n = 0; n < 40; n++)
            send(t_req'($urandom_range(1, 3)), pick_target());

        while (request_backlog.size() != 0 || i_in_valid || expected_responses.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("fifo_with_cancel_and_promote_top regression: pass");
        end else begin
            $display("fifo_with_cancel_and_promote_top regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fcp_pkg.sv
rtl/fcp_cell.sv
rtl/fifo_with_cancel_and_promote_top.sv
test/tb_fifo_with_cancel_and_promote_top.sv
